FILE: hdl/sme_pkg.sv
// Shared types and constants for the stack machine execute block.
`timescale 1ns / 1ps
package sme_pkg;

    localparam int unsigned PC_W = 23;
    localparam int unsigned IMM_W = 24;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned FC_W = 16;

    typedef enum logic [7:0] {
        OP_HALT = 8'd0, OP_PUSHC = 8'd1, OP_ADD = 8'd2, OP_SUB = 8'd3,
        OP_MUL = 8'd4, OP_DIV = 8'd5, OP_MOD = 8'd6, OP_RDINT = 8'd7,
        OP_WRINT = 8'd8, OP_RDCHR = 8'd9, OP_WRCHR = 8'd10, OP_PUSHG = 8'd11,
        OP_POPG = 8'd12, OP_ASF = 8'd13, OP_RSF = 8'd14, OP_PUSHL = 8'd15,
        OP_POPL = 8'd16, OP_EQ = 8'd17, OP_NE = 8'd18, OP_LT = 8'd19,
        OP_LE = 8'd20, OP_GT = 8'd21, OP_GE = 8'd22, OP_JMP = 8'd23,
        OP_BRF = 8'd24, OP_BRT = 8'd25, OP_CALL = 8'd26, OP_RET = 8'd27,
        OP_DROP = 8'd28, OP_PUSHR = 8'd29, OP_POPR = 8'd30, OP_DUP = 8'd31
    } t_op;

    typedef enum logic [3:0] {
        ERR_NONE = 4'd0, ERR_UNDER = 4'd1, ERR_FSIZE = 4'd2, ERR_FUNDER = 4'd3,
        ERR_PUSHL = 4'd4, ERR_POPL = 4'd5, ERR_CALL = 4'd6, ERR_DROP = 4'd7,
        ERR_POPR = 4'd8, ERR_TARGET = 4'd9, ERR_OVER = 4'd10
    } t_err;

    localparam logic [1:0] WK_NONE = 2'd0;
    localparam logic [1:0] WK_INT = 2'd1;
    localparam logic [1:0] WK_CHR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD1, ST_RD2, ST_EXEC, ST_DIV, ST_OUT
    } t_state;

    typedef struct packed {
        logic [7:0]        command;
        logic [IMM_W-1:0]  immediate;
        logic [DATA_W-1:0] read_value;
    } t_in;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic [1:0]        write_kind;
        logic [DATA_W-1:0] write_value;
        logic              divide_by_zero;
        logic              halted;
        logic [3:0]        error_code;
    } t_out;

endpackage

FILE: hdl/sme_if.sv
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
interface sme_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/stack_machine_execute.sv
// Top level: stack machine instruction executor.
//
// i_cmd (sink) takes one instruction beat: command, immediate, read_value.
// o_res (source) gives one result beat per instruction: next_pc, write
// request, divide-by-zero flag, halted and error code.
// i_cfg_we / i_cfg_data write code_size; write only while the block is idle.
// The operand stack RAM has one read and one write port, the globals RAM a
// single shared port; both have registered reads. Every instruction reads
// the stack once (RD1), two-operand ones read again (RD2), then execute and
// write back (EXEC); the result is valid the cycle after EXEC. Div and mod
// with a nonzero divisor go on from EXEC in the bit-serial divider (DIV),
// and their result is registered when the divider finishes. The next
// instruction is accepted in the cycle after the result beat leaves, never
// while a result is pending. While the receiver stalls the block holds its result.
// Reset (synchronous, active low) clears pc, sp, fp, return value, frame
// count and the stopped flag; the RAMs are not cleared. After an error or
// halt every instruction returns halted with pc unchanged.
`timescale 1ns / 1ps
module stack_machine_execute #(
    parameter int unsigned STACK_DEPTH  = 1024,
    parameter int unsigned GLOBAL_DEPTH = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sme_pkg::PC_W-1:0]   i_cfg_data,
    sme_if.sink                        i_cmd,
    sme_if.source                      o_res
);
    localparam int unsigned SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned GA_W = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;
    localparam int unsigned DW = sme_pkg::DATA_W;
    localparam int unsigned PW = sme_pkg::PC_W;
    localparam int unsigned FW = sme_pkg::FC_W;
    // signed compare width covering immediates and stack pointers
    localparam int unsigned CW = ((SP_W > 24) ? SP_W : 24) + 2;

    logic [DW-1:0] r_stk [STACK_DEPTH];
    logic [DW-1:0] r_glb [GLOBAL_DEPTH];

    sme_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_pc, r_code_size;
    logic [SP_W-1:0] r_sp, r_fp;
    logic [DW-1:0]   r_rv;
    logic [FW-1:0]   r_fc;
    logic            r_stopped;
    sme_pkg::t_in    r_in;
    sme_pkg::t_out   r_out;
    logic            r_out_valid;
    logic [DW-1:0]   r_a, r_b, r_stk_q, r_glb_q;

    // stack port controls
    logic            stk_re, stk_we, glb_we;
    logic [SA_W-1:0] stk_raddr, stk_waddr;
    logic [DW-1:0]   stk_wdata;
    logic [GA_W-1:0] glb_addr;

    // divider state
    logic [DW-1:0] r_dq, r_dr, r_dd;
    logic [5:0]    r_dcnt;
    logic          r_dneg_q, r_dneg_r;

    sme_pkg::t_op op;
    logic signed [CW-1:0] imm_s, sp_s, fp_s, idx_s;
    logic need1, need2, room;
    logic [SA_W-1:0] sp_m1, sp_m2, idx_a;
    // operand a: straight from the RAM read port in EXEC, held afterwards
    logic [DW-1:0] op_a;

    assign op    = sme_pkg::t_op'(r_in.command);
    assign imm_s = CW'(signed'(r_in.immediate));
    assign sp_s  = signed'(CW'(r_sp));
    assign fp_s  = signed'(CW'(r_fp));
    assign idx_s = fp_s + imm_s;
    assign need1 = r_sp >= SP_W'(1);
    assign need2 = r_sp >= SP_W'(2);
    assign room  = r_sp < SP_W'(STACK_DEPTH);
    assign sp_m1 = SA_W'(r_sp - SP_W'(1));
    assign sp_m2 = SA_W'(r_sp - SP_W'(2));
    assign idx_a = SA_W'(idx_s);
    assign op_a  = (r_state == sme_pkg::ST_EXEC) ? r_stk_q : r_a;

    assign i_cmd.ready = (r_state == sme_pkg::ST_IDLE) && !r_out_valid;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // memories
    always_ff @(posedge i_clk) begin
        if (stk_we) r_stk[stk_waddr] <= stk_wdata;
        if (stk_re) r_stk_q <= r_stk[stk_raddr];
        if (glb_we) r_glb[glb_addr] <= op_a;
        r_glb_q <= r_glb[glb_addr];
    end

    // which reads each opcode needs in ST_RD1 (addr1) and ST_RD2 (addr2)
    logic rd_two, bad_gidx;
    assign bad_gidx = imm_s < 0 || imm_s >= CW'(GLOBAL_DEPTH);
    always_comb begin
        case (op)
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
            sme_pkg::OP_MOD, sme_pkg::OP_EQ, sme_pkg::OP_NE, sme_pkg::OP_LT,
            sme_pkg::OP_LE, sme_pkg::OP_GT, sme_pkg::OP_GE: rd_two = 1'b1;
            default: rd_two = 1'b0;
        endcase
    end

    // execute-stage results
    logic [DW-1:0] alu;
    logic signed [DW-1:0] sa, sb;
    assign sa = signed'(op_a);
    assign sb = signed'(r_b);
    always_comb begin
        case (op)
            sme_pkg::OP_ADD: alu = op_a + r_b;
            sme_pkg::OP_SUB: alu = op_a - r_b;
            sme_pkg::OP_MUL: alu = op_a * r_b;
            sme_pkg::OP_EQ:  alu = DW'(op_a == r_b);
            sme_pkg::OP_NE:  alu = DW'(op_a != r_b);
            sme_pkg::OP_LT:  alu = DW'(sa < sb);
            sme_pkg::OP_LE:  alu = DW'(!(sb < sa));
            sme_pkg::OP_GT:  alu = DW'(sb < sa);
            sme_pkg::OP_GE:  alu = DW'(!(sa < sb));
            default:         alu = op_a + r_b;
        endcase
    end

    // control and execute
    logic [PW-1:0] pc1, n_pc;
    logic [SP_W-1:0] n_sp, n_fp;
    logic [DW-1:0] n_rv;
    logic [FW-1:0] n_fc;
    sme_pkg::t_err err;
    logic [1:0] kind;
    logic [DW-1:0] wval;
    logic dz, halt, out_load, start_div, div_done;
    assign pc1 = r_pc + PW'(1);

    always_comb begin
        n_state = r_state;
        stk_re = 1'b0; stk_raddr = sp_m1;
        stk_we = 1'b0; stk_waddr = sp_m1; stk_wdata = op_a;
        glb_we = 1'b0; glb_addr = GA_W'(r_in.immediate);
        n_pc = pc1; n_sp = r_sp; n_fp = r_fp; n_rv = r_rv; n_fc = r_fc;
        err = sme_pkg::ERR_NONE; kind = sme_pkg::WK_NONE; wval = '0;
        dz = 1'b0; halt = 1'b0; out_load = 1'b0; start_div = 1'b0;
        div_done = 1'b0;
        unique case (r_state)
            sme_pkg::ST_IDLE: begin
                if (i_cmd.valid && i_cmd.ready) n_state = sme_pkg::ST_RD1;
            end
            sme_pkg::ST_RD1: begin
                // first read: second operand for binaries, else the single read
                stk_re = 1'b1;
                case (op)
                    sme_pkg::OP_RSF:  stk_raddr = SA_W'(r_fp - SP_W'(1));
                    sme_pkg::OP_PUSHL: stk_raddr = idx_a;
                    default:          stk_raddr = sp_m1;
                endcase
                n_state = rd_two ? sme_pkg::ST_RD2 : sme_pkg::ST_EXEC;
            end
            sme_pkg::ST_RD2: begin
                stk_re = 1'b1; stk_raddr = sp_m2;
                n_state = sme_pkg::ST_EXEC;
            end
            sme_pkg::ST_EXEC, sme_pkg::ST_DIV: begin
                if (r_state == sme_pkg::ST_DIV) begin
                    div_done = (r_dcnt == 6'd0);
                end
                if (r_state == sme_pkg::ST_EXEC || div_done) begin
                    out_load = 1'b1;
                    n_state = sme_pkg::ST_OUT;
                end
                if (r_stopped) begin
                    n_pc = r_pc; halt = 1'b1;
                end else begin
                    case (op)
                        sme_pkg::OP_HALT: halt = 1'b1;
                        sme_pkg::OP_PUSHC, sme_pkg::OP_RDINT, sme_pkg::OP_RDCHR,
                        sme_pkg::OP_PUSHG, sme_pkg::OP_PUSHR, sme_pkg::OP_CALL,
                        sme_pkg::OP_PUSHL, sme_pkg::OP_DUP: begin
                            if (op == sme_pkg::OP_CALL &&
                                (imm_s < 0 || imm_s > signed'(CW'(r_code_size))))
                                err = sme_pkg::ERR_CALL;
                            else if (op == sme_pkg::OP_PUSHL &&
                                     (idx_s < 0 || idx_s >= CW'(STACK_DEPTH)))
                                err = sme_pkg::ERR_PUSHL;
                            else if (op == sme_pkg::OP_DUP && !need1)
                                err = sme_pkg::ERR_UNDER;
                            else if (!room) err = sme_pkg::ERR_OVER;
                            else begin
                                stk_we = 1'b1; stk_waddr = SA_W'(r_sp);
                                n_sp = r_sp + SP_W'(1);
                                case (op)
                                    sme_pkg::OP_PUSHC:
                                        stk_wdata = DW'(signed'(r_in.immediate));
                                    sme_pkg::OP_PUSHG:
                                        stk_wdata = bad_gidx ? '0 : r_glb_q;
                                    sme_pkg::OP_PUSHR: stk_wdata = r_rv;
                                    sme_pkg::OP_CALL: begin
                                        stk_wdata = DW'(pc1);
                                        n_pc = PW'(r_in.immediate);
                                    end
                                    sme_pkg::OP_PUSHL, sme_pkg::OP_DUP:
                                        stk_wdata = r_stk_q;
                                    default: stk_wdata = r_in.read_value;
                                endcase
                            end
                        end
                        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
                        sme_pkg::OP_EQ, sme_pkg::OP_NE, sme_pkg::OP_LT,
                        sme_pkg::OP_LE, sme_pkg::OP_GT, sme_pkg::OP_GE: begin
                            if (!need2) err = sme_pkg::ERR_UNDER;
                            else begin
                                stk_we = 1'b1; stk_waddr = sp_m2; stk_wdata = alu;
                                n_sp = r_sp - SP_W'(1);
                            end
                        end
                        sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
                            if (!need2) err = sme_pkg::ERR_UNDER;
                            else if (r_b == '0) begin
                                dz = 1'b1; n_sp = r_sp - SP_W'(1);
                            end else if (r_state == sme_pkg::ST_EXEC) begin
                                // hand off to the divider
                                out_load = 1'b0; start_div = 1'b1;
                                n_state = sme_pkg::ST_DIV;
                            end else begin
                                stk_we = div_done; stk_waddr = sp_m2;
                                stk_wdata = (op == sme_pkg::OP_DIV)
                                    ? (r_dneg_q ? -r_dq : r_dq)
                                    : (r_dneg_r ? -r_dr : r_dr);
                                n_sp = r_sp - SP_W'(1);
                            end
                        end
                        sme_pkg::OP_WRINT, sme_pkg::OP_WRCHR: begin
                            if (!need1) err = sme_pkg::ERR_UNDER;
                            else begin
                                n_sp = r_sp - SP_W'(1);
                                kind = (op == sme_pkg::OP_WRINT) ? sme_pkg::WK_INT
                                                                 : sme_pkg::WK_CHR;
                                wval = (op == sme_pkg::OP_WRINT) ? op_a
                                                                 : {24'd0, op_a[7:0]};
                            end
                        end
                        sme_pkg::OP_POPG: begin
                            if (!need1) err = sme_pkg::ERR_UNDER;
                            else begin
                                n_sp = r_sp - SP_W'(1);
                                glb_we = !bad_gidx;
                            end
                        end
                        sme_pkg::OP_ASF: begin
                            if (imm_s < 0) err = sme_pkg::ERR_FSIZE;
                            else if (!room || sp_s + imm_s + 1 > CW'(STACK_DEPTH))
                                err = sme_pkg::ERR_OVER;
                            else begin
                                stk_we = 1'b1; stk_waddr = SA_W'(r_sp);
                                stk_wdata = DW'(r_fp);
                                n_fp = r_sp + SP_W'(1);
                                n_sp = SP_W'(sp_s + imm_s + 1);
                                n_fc = r_fc + FW'(1);
                            end
                        end
                        sme_pkg::OP_RSF: begin
                            if (r_fc == '0 || r_fp == '0 ||
                                op_a > DW'(STACK_DEPTH)) err = sme_pkg::ERR_FUNDER;
                            else begin
                                n_sp = r_fp - SP_W'(1); n_fp = SP_W'(op_a);
                                n_fc = r_fc - FW'(1);
                            end
                        end
                        sme_pkg::OP_POPL: begin
                            if (idx_s < 0 || idx_s >= CW'(STACK_DEPTH))
                                err = sme_pkg::ERR_POPL;
                            else if (!need1) err = sme_pkg::ERR_UNDER;
                            else begin
                                stk_we = 1'b1; stk_waddr = idx_a; stk_wdata = op_a;
                                n_sp = r_sp - SP_W'(1);
                            end
                        end
                        sme_pkg::OP_JMP: begin
                            if (imm_s < 0) err = sme_pkg::ERR_TARGET;
                            else n_pc = PW'(r_in.immediate);
                        end
                        sme_pkg::OP_BRF, sme_pkg::OP_BRT: begin
                            if (imm_s < 0) err = sme_pkg::ERR_TARGET;
                            else if (!need1) err = sme_pkg::ERR_UNDER;
                            else begin
                                n_sp = r_sp - SP_W'(1);
                                if ((op == sme_pkg::OP_BRF && op_a == '0) ||
                                    (op == sme_pkg::OP_BRT && op_a == DW'(1)))
                                    n_pc = PW'(r_in.immediate);
                            end
                        end
                        sme_pkg::OP_RET: begin
                            if (!need1) err = sme_pkg::ERR_UNDER;
                            else if (op_a[DW-1:PW] != '0) err = sme_pkg::ERR_TARGET;
                            else begin
                                n_sp = r_sp - SP_W'(1); n_pc = op_a[PW-1:0];
                            end
                        end
                        sme_pkg::OP_DROP: begin
                            if (imm_s < 0 || imm_s > sp_s) err = sme_pkg::ERR_DROP;
                            else n_sp = SP_W'(sp_s - imm_s);
                        end
                        sme_pkg::OP_POPR: begin
                            if (r_sp == '0) err = sme_pkg::ERR_POPR;
                            else begin
                                n_sp = r_sp - SP_W'(1); n_rv = op_a;
                            end
                        end
                        default: ;
                    endcase
                    if (err != sme_pkg::ERR_NONE) begin
                        stk_we = 1'b0; glb_we = 1'b0; start_div = 1'b0;
                        out_load = 1'b1; n_state = sme_pkg::ST_OUT;
                        n_pc = r_pc; halt = 1'b1; kind = sme_pkg::WK_NONE;
                        wval = '0; dz = 1'b0;
                    end
                end
            end
            sme_pkg::ST_OUT: n_state = sme_pkg::ST_IDLE;
            default: n_state = sme_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= sme_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // machine registers and operand capture
    logic commit;
    assign commit = out_load && !r_stopped && err == sme_pkg::ERR_NONE;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0; r_sp <= '0; r_fp <= '0; r_rv <= '0; r_fc <= '0;
            r_stopped <= 1'b0; r_code_size <= '0; r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_code_size <= i_cfg_data;
            if (commit) begin
                r_pc <= n_pc; r_sp <= n_sp; r_fp <= n_fp; r_rv <= n_rv; r_fc <= n_fc;
            end
            if (out_load && (halt || err != sme_pkg::ERR_NONE)) r_stopped <= 1'b1;
            if (out_load) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) r_in <= i_cmd.data;
        // first read lands as top (b for binaries, a for unary pops)
        if (r_state == sme_pkg::ST_RD2) r_b <= r_stk_q;
        if (r_state == sme_pkg::ST_EXEC) r_a <= r_stk_q;
        if (out_load) begin
            r_out.next_pc <= n_pc; r_out.write_kind <= kind;
            r_out.write_value <= wval; r_out.divide_by_zero <= dz;
            r_out.halted <= halt; r_out.error_code <= err;
        end
    end

    // bit-serial restoring divider on magnitudes
    logic [DW:0] trial;
    assign trial = {r_dr, r_dq[DW-1]} - {1'b0, r_dd};
    always_ff @(posedge i_clk) begin
        if (start_div) begin
            r_dq <= sa[DW-1] ? -op_a : op_a;
            r_dd <= sb[DW-1] ? -r_b : r_b;
            r_dr <= '0;
            r_dcnt <= 6'(DW);
            r_dneg_q <= sa[DW-1] ^ sb[DW-1];
            r_dneg_r <= sa[DW-1];
        end else if (r_state == sme_pkg::ST_DIV && r_dcnt != 6'd0) begin
            r_dcnt <= r_dcnt - 6'd1;
            if (!trial[DW]) begin
                r_dr <= trial[DW-1:0];
                r_dq <= {r_dq[DW-2:0], 1'b1};
            end else begin
                r_dr <= {r_dr[DW-2:0], r_dq[DW-1]};
                r_dq <= {r_dq[DW-2:0], 1'b0};
            end
        end
    end

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH)) else $error("stack pointer past depth");
    a_stop_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped && r_state != sme_pkg::ST_IDLE |=> $stable(r_pc))
        else $error("pc moved while stopped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != sme_pkg::ST_IDLE |-> !i_cmd.ready)
        else $error("accept while busy");
`endif
endmodule

FILE: verif/stack_machine_execute_test.sv
// Self-checking testbench for the stack machine execute block.
`timescale 1ns / 1ps
module stack_machine_execute_test;

    localparam int unsigned DEPTH  = 1024;
    localparam int unsigned GDEPTH = 256;
    localparam int unsigned STALL_LIMIT = 5000;

    // Instruction-level model of the machine plus the queue of expected result beats
    class vm_scoreboard;
        logic [31:0] stk [DEPTH];
        bit          stk_ok [DEPTH];
        logic [31:0] glb [GDEPTH];
        bit          glb_ok [GDEPTH];
        logic [22:0] pc;
        int unsigned sp, fp;
        logic [31:0] rv;
        logic [15:0] fc;
        bit          stopped;
        logic [22:0] code_size;
        sme_pkg::t_out pending [$];
        int          errors, results, div_zero_seen, writes_seen;
        sme_pkg::t_err last_err;

        function new();
            pc = '0; sp = 0; fp = 0; rv = '0; fc = '0; stopped = 0; code_size = '0;
            errors = 0; results = 0; div_zero_seen = 0; writes_seen = 0;
            last_err = sme_pkg::ERR_NONE;
            foreach (stk_ok[i]) stk_ok[i] = 0;
            foreach (glb_ok[i]) glb_ok[i] = 0;
        endfunction

        // stack read; clears ok on an entry never written
        function automatic logic [31:0] rd(int unsigned i, inout bit ok);
            if (!stk_ok[i]) ok = 0;
            return stk[i];
        endfunction

        // Execute one instruction; clean means no error, no halt, no unwritten read
        function automatic void exec(sme_pkg::t_in it, bit commit,
                                     output sme_pkg::t_out r, output bit clean);
            int          imm;
            longint      idx;
            logic [31:0] a, b, t;
            logic [22:0] npc;
            int unsigned nsp, nfp;
            logic [31:0] nrv;
            logic [15:0] nfc;
            sme_pkg::t_err err;
            bit          halt, ok, we, gwe;
            int unsigned wa, ga;
            logic [31:0] wd;
            r = '0;
            imm = $signed(it.immediate);
            npc = pc + 23'd1;
            nsp = sp; nfp = fp; nrv = rv; nfc = fc;
            err = sme_pkg::ERR_NONE; halt = 0; ok = 1; we = 0; gwe = 0;
            wa = 0; ga = 0; wd = '0; t = '0; idx = 0;
            if (stopped) begin
                r.next_pc = pc;
                r.halted = 1'b1;
                clean = 0;
                return;
            end
            case (it.command)
                sme_pkg::OP_HALT: halt = 1;
                sme_pkg::OP_PUSHC, sme_pkg::OP_RDINT, sme_pkg::OP_RDCHR,
                sme_pkg::OP_PUSHR: begin
                    if (nsp >= DEPTH) err = sme_pkg::ERR_OVER;
                    else begin
                        we = 1; wa = nsp; nsp++;
                        if (it.command == sme_pkg::OP_PUSHC) wd = 32'(imm);
                        else if (it.command == sme_pkg::OP_PUSHR) wd = nrv;
                        else wd = it.read_value;
                    end
                end
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
                sme_pkg::OP_MOD, sme_pkg::OP_EQ, sme_pkg::OP_NE, sme_pkg::OP_LT,
                sme_pkg::OP_LE, sme_pkg::OP_GT, sme_pkg::OP_GE: begin
                    if (nsp < 2) err = sme_pkg::ERR_UNDER;
                    else begin
                        a = rd(nsp - 2, ok);
                        b = rd(nsp - 1, ok);
                        if ((it.command == sme_pkg::OP_DIV ||
                             it.command == sme_pkg::OP_MOD) && b == '0) begin
                            // zero divisor: divisor dropped, dividend kept
                            r.divide_by_zero = 1'b1;
                            nsp--;
                        end else begin
                            case (it.command)
                                sme_pkg::OP_ADD: t = a + b;
                                sme_pkg::OP_SUB: t = a - b;
                                sme_pkg::OP_MUL: t = a * b;
                                sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
                                    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                                        t = (it.command == sme_pkg::OP_DIV) ? a : '0;
                                    else if (it.command == sme_pkg::OP_DIV)
                                        t = $signed(a) / $signed(b);
                                    else
                                        t = $signed(a) % $signed(b);
                                end
                                sme_pkg::OP_EQ: t = {31'b0, a == b};
                                sme_pkg::OP_NE: t = {31'b0, a != b};
                                sme_pkg::OP_LT: t = {31'b0, $signed(a) < $signed(b)};
                                sme_pkg::OP_LE: t = {31'b0, $signed(a) <= $signed(b)};
                                sme_pkg::OP_GT: t = {31'b0, $signed(a) > $signed(b)};
                                default: t = {31'b0, $signed(a) >= $signed(b)};
                            endcase
                            we = 1; wa = nsp - 2; wd = t; nsp--;
                        end
                    end
                end
                sme_pkg::OP_WRINT, sme_pkg::OP_WRCHR: begin
                    if (nsp < 1) err = sme_pkg::ERR_UNDER;
                    else begin
                        nsp--;
                        t = rd(nsp, ok);
                        r.write_kind = (it.command == sme_pkg::OP_WRINT) ? sme_pkg::WK_INT
                                                                         : sme_pkg::WK_CHR;
                        r.write_value = (it.command == sme_pkg::OP_WRINT) ? t
                                                                          : {24'b0, t[7:0]};
                    end
                end
                sme_pkg::OP_PUSHG: begin
                    if (nsp >= DEPTH) err = sme_pkg::ERR_OVER;
                    else begin
                        if (imm >= 0 && imm < GDEPTH) begin
                            if (!glb_ok[imm]) ok = 0;
                            wd = glb[imm];
                        end else wd = '0;
                        we = 1; wa = nsp; nsp++;
                    end
                end
                sme_pkg::OP_POPG: begin
                    if (nsp < 1) err = sme_pkg::ERR_UNDER;
                    else begin
                        nsp--;
                        t = rd(nsp, ok);
                        if (imm >= 0 && imm < GDEPTH) begin
                            gwe = 1; ga = imm;
                        end
                    end
                end
                sme_pkg::OP_ASF: begin
                    if (imm < 0) err = sme_pkg::ERR_FSIZE;
                    else if (nsp >= DEPTH || longint'(nsp) + 1 + imm > DEPTH)
                        err = sme_pkg::ERR_OVER;
                    else begin
                        we = 1; wa = nsp; wd = nfp;
                        nfp = nsp + 1;
                        nsp = nfp + imm;
                        nfc++;
                    end
                end
                sme_pkg::OP_RSF: begin
                    if (nfc == 0 || nfp == 0) err = sme_pkg::ERR_FUNDER;
                    else begin
                        t = rd(nfp - 1, ok);
                        if (t > DEPTH) err = sme_pkg::ERR_FUNDER;
                        else begin
                            nsp = nfp - 1; nfp = t; nfc--;
                        end
                    end
                end
                sme_pkg::OP_PUSHL: begin
                    idx = longint'(nfp) + imm;
                    if (idx < 0 || idx >= DEPTH) err = sme_pkg::ERR_PUSHL;
                    else if (nsp >= DEPTH) err = sme_pkg::ERR_OVER;
                    else begin
                        wd = rd(idx, ok);
                        we = 1; wa = nsp; nsp++;
                    end
                end
                sme_pkg::OP_POPL: begin
                    idx = longint'(nfp) + imm;
                    if (idx < 0 || idx >= DEPTH) err = sme_pkg::ERR_POPL;
                    else if (nsp < 1) err = sme_pkg::ERR_UNDER;
                    else begin
                        nsp--;
                        wd = rd(nsp, ok);
                        we = 1; wa = idx;
                    end
                end
                sme_pkg::OP_JMP: begin
                    if (imm < 0) err = sme_pkg::ERR_TARGET;
                    else npc = imm;
                end
                sme_pkg::OP_BRF, sme_pkg::OP_BRT: begin
                    if (imm < 0) err = sme_pkg::ERR_TARGET;
                    else if (nsp < 1) err = sme_pkg::ERR_UNDER;
                    else begin
                        nsp--;
                        t = rd(nsp, ok);
                        if ((it.command == sme_pkg::OP_BRF && t == 0) ||
                            (it.command == sme_pkg::OP_BRT && t == 1))
                            npc = imm;
                    end
                end
                sme_pkg::OP_CALL: begin
                    if (imm < 0 || imm > code_size) err = sme_pkg::ERR_CALL;
                    else if (nsp >= DEPTH) err = sme_pkg::ERR_OVER;
                    else begin
                        we = 1; wa = nsp; wd = {9'b0, npc}; nsp++;
                        npc = imm;
                    end
                end
                sme_pkg::OP_RET: begin
                    if (nsp < 1) err = sme_pkg::ERR_UNDER;
                    else begin
                        t = rd(nsp - 1, ok);
                        if (t > 32'h007F_FFFF) err = sme_pkg::ERR_TARGET;
                        else begin
                            nsp--; npc = t[22:0];
                        end
                    end
                end
                sme_pkg::OP_DROP: begin
                    if (imm < 0 || imm > nsp) err = sme_pkg::ERR_DROP;
                    else nsp -= imm;
                end
                sme_pkg::OP_POPR: begin
                    if (nsp == 0) err = sme_pkg::ERR_POPR;
                    else begin
                        nsp--; nrv = rd(nsp, ok);
                    end
                end
                sme_pkg::OP_DUP: begin
                    if (nsp < 1) err = sme_pkg::ERR_UNDER;
                    else if (nsp >= DEPTH) err = sme_pkg::ERR_OVER;
                    else begin
                        wd = rd(nsp - 1, ok);
                        we = 1; wa = nsp; nsp++;
                    end
                end
                default: ;
            endcase
            if (err != sme_pkg::ERR_NONE) begin
                r = '0;
                r.next_pc = pc;
                r.halted = 1'b1;
                r.error_code = err;
                if (commit) begin
                    stopped = 1;
                    last_err = err;
                end
                clean = 0;
                return;
            end
            clean = ok && !halt;
            r.next_pc = npc;
            r.halted = halt;
            if (commit) begin
                if (we) begin
                    stk[wa] = wd; stk_ok[wa] = 1;
                end
                if (gwe) begin
                    glb[ga] = t; glb_ok[ga] = 1;
                end
                pc = npc; sp = nsp; fp = nfp; rv = nrv; fc = nfc;
                if (halt) stopped = 1;
            end
        endfunction

        // Accepted instruction beat: advance the model, queue the expected result
        function void note_input(sme_pkg::t_in it);
            sme_pkg::t_out r;
            bit   clean;
            exec(it, 1, r, clean);
            pending.push_back(r);
        endfunction

        // Result beat: compare field by field with the oldest expectation
        function void check_result(sme_pkg::t_out got);
            sme_pkg::t_out exp_r;
            results++;
            if (got.divide_by_zero) div_zero_seen++;
            if (got.write_kind != sme_pkg::WK_NONE) writes_seen++;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected: %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.next_pc !== exp_r.next_pc)
                $display("%0t: next_pc exp %h got %h", $time, exp_r.next_pc, got.next_pc);
            if (got.write_kind !== exp_r.write_kind)
                $display("%0t: write_kind exp %0d got %0d", $time,
                         exp_r.write_kind, got.write_kind);
            if (got.write_value !== exp_r.write_value)
                $display("%0t: write_value exp %h got %h", $time,
                         exp_r.write_value, got.write_value);
            if (got.divide_by_zero !== exp_r.divide_by_zero)
                $display("%0t: divide_by_zero exp %b got %b", $time,
                         exp_r.divide_by_zero, got.divide_by_zero);
            if (got.halted !== exp_r.halted)
                $display("%0t: halted exp %b got %b", $time, exp_r.halted, got.halted);
            if (got.error_code !== exp_r.error_code)
                $display("%0t: error_code exp %0d got %0d", $time,
                         exp_r.error_code, got.error_code);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [sme_pkg::PC_W-1:0] i_cfg_data;
    bit   noisy;
    int   quiet_cycles;
    vm_scoreboard sb;

    sme_if #(.T(sme_pkg::t_in))  cmd_if ();
    sme_if #(.T(sme_pkg::t_out)) res_if ();

    stack_machine_execute u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure while noisy
    initial res_if.ready = 1'b0;
    always @(negedge i_clk)
        res_if.ready <= noisy ? ($urandom_range(99) >= 25) : 1'b1;

    // Monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) sb.note_input(cmd_if.data);
            if (res_if.valid && res_if.ready) sb.check_result(res_if.data);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
                $display("stack_machine_execute regression: fail");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drive one instruction beat; starts and ends at a falling edge
    task automatic send(sme_pkg::t_in it);
        while (noisy && $urandom_range(99) < 25) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= it;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_op(sme_pkg::t_op op, int imm, logic [31:0] rdv = '0);
        sme_pkg::t_in it;
        it.command = op;
        it.immediate = imm[23:0];
        it.read_value = rdv;
        send(it);
    endtask

    // Code size write, only with nothing in flight
    task automatic set_code_size(logic [sme_pkg::PC_W-1:0] v);
        cmd_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.code_size = v;
    endtask

    // Random candidate instruction, operands biased toward the useful range
    function automatic sme_pkg::t_in rand_instr();
        sme_pkg::t_in it;
        int  imm;
        it.command = ($urandom_range(19) == 0) ? 8'($urandom_range(32, 255))
                                               : 8'($urandom_range(1, 31));
        if (sb.sp > 600 && $urandom_range(3) == 0) it.command = sme_pkg::OP_DROP;
        it.read_value = $urandom;
        imm = $urandom_range(0, 31);
        case (it.command)
            sme_pkg::OP_PUSHC: imm = $signed(24'($urandom));
            sme_pkg::OP_PUSHG, sme_pkg::OP_POPG:
                imm = ($urandom_range(9) == 0) ? $signed(24'($urandom))
                                               : $urandom_range(0, GDEPTH - 1);
            sme_pkg::OP_ASF: imm = $urandom_range(0, 6);
            sme_pkg::OP_PUSHL, sme_pkg::OP_POPL: imm = $urandom_range(0, 12) - 4;
            sme_pkg::OP_JMP, sme_pkg::OP_BRF, sme_pkg::OP_BRT:
                imm = ($urandom_range(3) == 0) ? $urandom_range(0, 'h7FFFFF)
                                               : $urandom_range(0, 64);
            sme_pkg::OP_CALL:
                imm = $urandom_range(0, (sb.code_size > 200) ? 200 : sb.code_size);
            sme_pkg::OP_DROP: imm = $urandom_range(0, (sb.sp > 3) ? 3 : sb.sp);
            default: ;
        endcase
        it.immediate = imm[23:0];
        return it;
    endfunction

    // A legal instruction: no error, no halt, no read of an unwritten entry
    task automatic send_random();
        sme_pkg::t_in  it;
        sme_pkg::t_out r;
        bit   clean;
        int   tries;
        tries = 0;
        do begin
            it = rand_instr();
            sb.exec(it, 0, r, clean);
            tries++;
        end while (!clean && tries < 64);
        if (!clean) begin
            it.command = sme_pkg::OP_PUSHC;
            it.immediate = 24'($urandom);
        end
        send(it);
    endtask

    initial begin
        sme_pkg::t_in  it;
        sme_pkg::t_out r;
        bit   clean;
        logic [sme_pkg::PC_W-1:0] sizes [4];
        sb = new();
        noisy = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, signed overflow, zero divisor, globals, frames, pc wrap
        set_code_size(23'h7FFFFF);
        send_op(sme_pkg::OP_PUSHC, 'h7FFFFF);
        send_op(sme_pkg::OP_PUSHC, -'h800000);
        send_op(sme_pkg::OP_ADD, 0);
        send_op(sme_pkg::OP_RDINT, 0, 32'h8000_0000);
        send_op(sme_pkg::OP_PUSHC, -1);
        send_op(sme_pkg::OP_DIV, 0);
        send_op(sme_pkg::OP_PUSHC, 0);
        send_op(sme_pkg::OP_MOD, 0);
        send_op(sme_pkg::OP_WRINT, 0);
        send_op(sme_pkg::OP_RDCHR, 0, 32'hFFFF_FFFF);
        send_op(sme_pkg::OP_WRCHR, 0);
        send_op(sme_pkg::OP_RDINT, 0, 32'h7FFF_FFFF);
        send_op(sme_pkg::OP_POPG, GDEPTH - 1);
        send_op(sme_pkg::OP_PUSHG, GDEPTH - 1);
        send_op(sme_pkg::OP_PUSHG, GDEPTH);
        send_op(sme_pkg::OP_LT, 0);
        send_op(sme_pkg::OP_ASF, 2);
        send_op(sme_pkg::OP_RDINT, 0, 32'd5);
        send_op(sme_pkg::OP_POPL, 0);
        send_op(sme_pkg::OP_PUSHL, 0);
        send_op(sme_pkg::OP_POPR, 0);
        send_op(sme_pkg::OP_PUSHR, 0);
        send_op(sme_pkg::OP_DUP, 0);
        send_op(sme_pkg::OP_EQ, 0);
        send_op(sme_pkg::OP_RSF, 0);
        send_op(sme_pkg::OP_JMP, 'h7FFFFF);
        it = '{command: 8'hFF, immediate: 24'hFFFFFF, read_value: '0};
        send(it);
        send_op(sme_pkg::OP_DROP, 1);

        // Random phases over several code sizes; the first has a quiet stretch
        sizes[0] = 23'h7FFFFF;
        sizes[1] = '0;
        sizes[2] = 23'($urandom_range(1, 'h7FFFFF));
        sizes[3] = 23'd40;
        for (int p = 0; p < 4; p++) begin
            set_code_size(sizes[p]);
            for (int n = 0; n < 500; n++) begin
                noisy = !(p == 0 && n < 300);
                send_random();
            end
        end

        // Stop the machine with a halt or a fatal error, then probe the stopped state
        do begin
            it = rand_instr();
            if ($urandom_range(3) == 0) it.command = sme_pkg::OP_HALT;
            else if ($urandom_range(1) == 0) it.immediate = 24'h800000 | 24'($urandom);
            sb.exec(it, 0, r, clean);
        end while (!r.halted);
        send(it);
        repeat (5) send_random();
        cmd_if.valid <= 1'b0;

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("%0d results checked, %0d writes, %0d zero divisors; stop code %0d",
                 sb.results, sb.writes_seen, sb.div_zero_seen, sb.last_err);
        $display("code sizes 0, max, random and small; stalls on both sides");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("stack_machine_execute regression: pass");
        else
            $display("stack_machine_execute regression: fail");
        $finish;
    end

endmodule

FILE: stack_machine_execute.f
hdl/sme_pkg.sv
hdl/sme_if.sv
hdl/stack_machine_execute.sv
verif/stack_machine_execute_test.sv
